/* rtl/core/pdle_pkg.sv */
// Shared types, constants and helpers of the pixel difference line extractor.
`default_nettype none

package pdle_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } t_pix;

    typedef struct packed {
        logic [PIX_W-1:0] line_value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             frame_end;
    } t_res;

    // 255 minus the absolute difference of two pixels
    function automatic logic [PIX_W-1:0] closeness(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return PIX_MAX - diff;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pdle_if.sv */
// Valid/ready stream interfaces for pixel words and result words.
`default_nettype none

interface pdle_pix_if;
    logic          valid;
    logic          ready;
    pdle_pkg::t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pdle_res_if;
    logic          valid;
    logic          ready;
    pdle_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/pixel_difference_line_extractor.sv */
// Top level of the pixel difference line extractor: line memory, issue stage, result register.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+------------------------------------------
//  i_pix    | in  | valid/ready        | pixel (8b), raster order
//  o_res    | out | valid/ready        | line_value (8b), row, column, frame_end
//  i_cfg_*  | in  | write enable only  | idx 0 frame_width, idx 1 frame_height
//
//  One pixel word is taken per cycle while each pixel yields at most one result and
//  the output does not stall. Last-row pixels past column 0 yield two results (three
//  at the last column), so there the input waits while more than one is owed; the
//  single-entry result register passes one result per cycle. A first-row pixel yields none.
//  Reset (synchronous, active low) clears counters, previous pixel and control;
//  the line memory is not cleared. Output stalls back up through the issue stage.
`default_nettype none

module pixel_difference_line_extractor #(
    parameter int MAX_WIDTH = pdle_pkg::MAX_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    pdle_pix_if.sink                           i_pix,
    pdle_res_if.source                         o_res,
    input  wire                                i_cfg_we,
    input  wire [pdle_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pdle_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Column address width and a width wide enough to compare against MAX_WIDTH
    localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WMB = $clog2(MAX_WIDTH + 1);
    localparam int WCW = ((WMB > pdle_pkg::FW_W) ? WMB : pdle_pkg::FW_W) + 1;

    localparam logic [WCW-1:0] W_MIN = WCW'(2);
    localparam logic [WCW-1:0] W_MAX = WCW'(MAX_WIDTH);
    localparam logic [pdle_pkg::FH_W-1:0] H_MIN = pdle_pkg::FH_W'(2);

    // Configuration registers
    logic [pdle_pkg::FW_W-1:0] r_fw;
    logic [pdle_pkg::FH_W-1:0] r_fh;

    // Frame position and previous pixel
    logic [pdle_pkg::ROW_W-1:0] r_row;
    logic [AW-1:0]              r_col;
    logic [pdle_pkg::PIX_W-1:0] r_prev;

    // Line memory: holds the row above the current pixel
    logic [pdle_pkg::PIX_W-1:0] mem [MAX_WIDTH];

    // Issue stage: one accepted pixel and the results still owed for it
    logic [2:0]                 r_need;
    logic [2:0]                 n_need;
    logic [pdle_pkg::PIX_W-1:0] r_s1_pix;
    logic [pdle_pkg::PIX_W-1:0] r_s1_prev;
    logic [pdle_pkg::ROW_W-1:0] r_s1_row;
    logic [AW-1:0]              r_s1_col;
    logic                       r_s1_lastcol;
    logic                       r_s1_lastrow;
    logic [pdle_pkg::PIX_W-1:0] r_above;
    logic [pdle_pkg::PIX_W-1:0] r_right;

    // Result register
    logic           r_out_valid;
    pdle_pkg::t_res r_out;
    pdle_pkg::t_res n_out;

    logic [WCW-1:0]             w_ext;
    logic [WCW-1:0]             w_eff;
    logic [pdle_pkg::FH_W-1:0]  h_eff;
    logic                       last_col;
    logic                       last_row;
    logic [2:0]                 acc_need;
    logic [AW-1:0]              rd_next;
    logic                       out_free;
    logic                       emit;
    logic                       in_ready;
    logic                       accept;

    // Effective frame size: clamp width to [2, MAX_WIDTH], height to at least 2
    always_comb begin
        w_ext = WCW'(r_fw);
        if (w_ext < W_MIN) begin
            w_eff = W_MIN;
        end else if (w_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_ext;
        end
        h_eff = (r_fh < H_MIN) ? H_MIN : r_fh;
    end

    assign last_col = WCW'(r_col) >= (w_eff - WCW'(1));
    assign last_row = r_row >= (h_eff - pdle_pkg::FH_W'(1));
    assign rd_next  = r_col + AW'(1);

    // Results owed by the incoming pixel: above row, left neighbor, frame end
    assign acc_need = {last_row & last_col,
                       last_row & (r_col != '0),
                       r_row != '0};

    assign out_free = !r_out_valid || o_res.ready;
    assign emit     = (r_need != 3'b000) && out_free;
    // Take a new pixel when nothing is owed or the last owed result leaves now
    assign in_ready = (r_need == 3'b000) || (emit && $onehot(r_need));
    assign accept   = i_pix.valid && in_ready;

    assign i_pix.ready   = in_ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // Pick the lowest owed result and retire its bit
    always_comb begin
        n_out  = '0;
        n_need = r_need;
        if (r_need[0]) begin
            n_need[0]        = 1'b0;
            n_out.line_value = r_s1_lastcol ? '0 :
                               (pdle_pkg::closeness(r_right, r_above) &
                                pdle_pkg::closeness(r_s1_pix, r_above));
            n_out.row        = r_s1_row - pdle_pkg::ROW_W'(1);
            n_out.column     = pdle_pkg::COL_W'(r_s1_col);
            n_out.frame_end  = 1'b0;
        end else if (r_need[1]) begin
            n_need[1]        = 1'b0;
            n_out.line_value = pdle_pkg::closeness(r_s1_pix, r_s1_prev);
            n_out.row        = r_s1_row;
            n_out.column     = pdle_pkg::COL_W'(r_s1_col - AW'(1));
            n_out.frame_end  = 1'b0;
        end else begin
            n_need[2]        = 1'b0;
            n_out.line_value = '0;
            n_out.row        = r_s1_row;
            n_out.column     = pdle_pkg::COL_W'(r_s1_col);
            n_out.frame_end  = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= pdle_pkg::RST_FRAME_WIDTH;
            r_fh <= pdle_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdle_pkg::CFG_FRAME_WIDTH: begin
                    r_fw <= i_cfg_data[pdle_pkg::FW_W-1:0];
                end
                pdle_pkg::CFG_FRAME_HEIGHT: begin
                    r_fh <= i_cfg_data[pdle_pkg::FH_W-1:0];
                end
            endcase
        end
    end

    // Line memory: both reads and the write land on the accept edge, so the
    // reads see the row above and a pixel taken next cycle sees this write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above    <= mem[r_col];
            r_right    <= mem[rd_next];
            mem[r_col] <= i_pix.payload.pixel;
        end
    end

    // Frame counters and the issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_prev <= '0;
            r_need <= '0;
        end else if (accept) begin
            r_prev <= i_pix.payload.pixel;
            r_need <= acc_need;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : (r_row + pdle_pkg::ROW_W'(1));
            end else begin
                r_col <= r_col + AW'(1);
            end
        end else if (emit) begin
            r_need <= n_need;
        end
    end

    // Issue-stage payload, loaded with each accepted pixel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix     <= i_pix.payload.pixel;
            r_s1_prev    <= r_prev;
            r_s1_row     <= r_row;
            r_s1_col     <= r_col;
            r_s1_lastcol <= last_col;
            r_s1_lastrow <= last_row;
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Two or more owed results must hold off the input
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$onehot0(r_need) |-> !in_ready)
        else $error("input taken while several results are owed");

    // The frame-end result is owed only for the last pixel of the last row
    a_end_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need[2] |-> r_s1_lastrow && r_s1_lastcol)
        else $error("frame end owed outside the last row");

    // A frame-end word carries a zero value
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.line_value == '0)
        else $error("frame end word with nonzero value");

    // Taking the last pixel of a row wraps the column counter
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && last_col |=> r_col == '0)
        else $error("column counter did not wrap");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the pixel difference line extractor.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_W          = pdle_pkg::MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int SMALL_ITEMS    = 36;
    localparam int MAX_REPORTS    = 10;
    localparam int RUN_LIMIT_NS   = 2_000_000;

    typedef struct {
        bit                              is_reg;
        logic [pdle_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [pdle_pkg::CFG_DATA_W-1:0] value;
        int                              n_known;   // -1: take the results from the predictor
        pdle_pkg::t_res                  k0;
        pdle_pkg::t_res                  k1;
        pdle_pkg::t_res                  k2;
    } t_stim_row;

    localparam pdle_pkg::t_res NO_RES = '0;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [pdle_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pdle_pkg::CFG_DATA_W-1:0] cfg_data;

    pdle_pix_if pix_ch ();
    pdle_res_if res_ch ();

    pixel_difference_line_extractor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor state: a private copy of the frame walk and of both registers.
    logic [pdle_pkg::PIX_W-1:0] line_mem [MAX_W];
    logic [pdle_pkg::PIX_W-1:0] prev_pix;
    logic [pdle_pkg::ROW_W-1:0] row_at;
    logic [pdle_pkg::COL_W-1:0] col_at;
    logic [pdle_pkg::FW_W-1:0]  width_reg;
    logic [pdle_pkg::FH_W-1:0]  height_reg;

    pdle_pkg::t_res due_results [$];
    t_stim_row      stim_rows [$];
    int             fail_count;
    int             src_idle_pct;
    int             sink_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: a hang anywhere ends the run as a failure.
    initial begin
        #RUN_LIMIT_NS;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int eff_width();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_W) return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg < 2) ? 2 : int'(height_reg);
    endfunction

    // 255 less the distance between two pixels
    function automatic logic [pdle_pkg::PIX_W-1:0] match_level(
        input logic [pdle_pkg::PIX_W-1:0] a,
        input logic [pdle_pkg::PIX_W-1:0] b);
        int d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return pdle_pkg::PIX_W'(255 - d);
    endfunction

    function automatic pdle_pkg::t_res mk_res(input int v, input int r, input int c,
                                              input bit e);
        pdle_pkg::t_res x;
        x.line_value = v[pdle_pkg::PIX_W-1:0];
        x.row        = r[pdle_pkg::ROW_W-1:0];
        x.column     = c[pdle_pkg::COL_W-1:0];
        x.frame_end  = e;
        return x;
    endfunction

    // Walk one accepted pixel through the frame; queue its results when record is set.
    task automatic predict_line_values(input logic [pdle_pkg::PIX_W-1:0] p, input bit record);
        int             w;
        int             h;
        bit             last_col;
        bit             last_row;
        pdle_pkg::t_res x;
        w = eff_width();
        h = eff_height();
        last_col = int'(col_at) >= w - 1;
        last_row = int'(row_at) >= h - 1;
        // Pixel below completes the row above.
        if (row_at >= 1) begin
            x = mk_res(0, int'(row_at) - 1, int'(col_at), 1'b0);
            if (!last_col)
                x.line_value = match_level(line_mem[col_at + 1], line_mem[col_at]) &
                               match_level(p, line_mem[col_at]);
            if (record) due_results.push_back(x);
        end
        // Last row: only the horizontal term, one pixel behind.
        if (last_row && col_at >= 1) begin
            x = mk_res(int'(match_level(p, prev_pix)), int'(row_at), int'(col_at) - 1, 1'b0);
            if (record) due_results.push_back(x);
        end
        if (last_row && last_col) begin
            x = mk_res(0, int'(row_at), int'(col_at), 1'b1);
            if (record) due_results.push_back(x);
        end
        line_mem[col_at] = p;
        prev_pix = p;
        if (last_col) begin
            col_at = '0;
            row_at = last_row ? '0 : row_at + 1'b1;
        end else begin
            col_at = col_at + 1'b1;
        end
    endtask

    // Pick pixels that often sit close to their neighbors so the AND of both terms varies.
    function automatic logic [pdle_pkg::PIX_W-1:0] pick_pixel();
        int sel;
        int t;
        sel = $urandom_range(0, 7);
        if (sel <= 2) return pdle_pkg::PIX_W'($urandom_range(0, 255));
        if (sel == 3) return $urandom_range(0, 1) ? pdle_pkg::PIX_MAX : '0;
        if (sel <= 5) t = int'(prev_pix) + int'($urandom_range(0, 6)) - 3;
        else t = int'(line_mem[col_at]) + int'($urandom_range(0, 6)) - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return pdle_pkg::PIX_W'(t);
    endfunction

    // Hold the pixel word until taken; idle the line at random first.
    task automatic push_pixel(input logic [pdle_pkg::PIX_W-1:0] p, input bit record);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid   <= 1'b1;
        pix_ch.payload <= p;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        predict_line_values(p, record);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pdle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdle_pkg::CFG_DATA_W-1:0] data);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == pdle_pkg::CFG_FRAME_WIDTH) width_reg = data[pdle_pkg::FW_W-1:0];
        else height_reg = data[pdle_pkg::FH_W-1:0];
    endtask

    task automatic finish_frame();
        do push_pixel(pick_pixel(), 1'b1);
        while (row_at != 0 || col_at != 0);
    endtask

    // Mid-frame: shrink a dimension or just pause; never grow, so no unwritten entry is read.
    task automatic mid_frame_event();
        case ($urandom_range(0, 2))
            0: write_reg(pdle_pkg::CFG_FRAME_WIDTH,
                         pdle_pkg::CFG_DATA_W'($urandom_range(2, eff_width())));
            1: write_reg(pdle_pkg::CFG_FRAME_HEIGHT,
                         pdle_pkg::CFG_DATA_W'($urandom_range(2, eff_height())));
            default: settle();
        endcase
    endtask

    task automatic run_small_frames(input int target);
        int sent;
        int cut;
        int k;
        sent = 0;
        while (sent < target) begin
            // Resize at each frame start and now and then mid-frame; sizes below two act as two.
            if ($urandom_range(0, 9) == 0)
                write_reg(pdle_pkg::CFG_FRAME_WIDTH, pdle_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            else
                write_reg(pdle_pkg::CFG_FRAME_WIDTH, pdle_pkg::CFG_DATA_W'($urandom_range(2, 12)));
            if ($urandom_range(0, 9) == 0)
                write_reg(pdle_pkg::CFG_FRAME_HEIGHT, pdle_pkg::CFG_DATA_W'($urandom_range(0, 1)));
            else
                write_reg(pdle_pkg::CFG_FRAME_HEIGHT, pdle_pkg::CFG_DATA_W'($urandom_range(2, 6)));
            cut = ($urandom_range(0, 3) == 0) ?
                  int'($urandom_range(1, eff_width() * eff_height() - 1)) : -1;
            k = 0;
            do begin
                if (k == cut) mid_frame_event();
                push_pixel(pick_pixel(), 1'b1);
                k++;
                sent++;
            end while (row_at != 0 || col_at != 0);
        end
    endtask

    task automatic add_reg(input logic [pdle_pkg::CFG_IDX_W-1:0] idx, input int v);
        t_stim_row s;
        s = '{1'b1, idx, pdle_pkg::CFG_DATA_W'(v), 0, NO_RES, NO_RES, NO_RES};
        stim_rows.push_back(s);
    endtask

    task automatic add_pix(input int p, input int n, input pdle_pkg::t_res a,
                           input pdle_pkg::t_res b, input pdle_pkg::t_res c);
        t_stim_row s;
        s = '{1'b0, pdle_pkg::CFG_FRAME_WIDTH, pdle_pkg::CFG_DATA_W'(p), n, a, b, c};
        stim_rows.push_back(s);
    endtask

    // Sink: drop ready at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare each taken result word with the oldest one owed.
    always @(posedge i_clk) begin : result_check
        pdle_pkg::t_res got;
        pdle_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: value=%0d row=%0d col=%0d end=%0b",
                             got.line_value, got.row, got.column, got.frame_end);
            end else begin
                want = due_results.pop_front();
                if (got.line_value !== want.line_value || got.row !== want.row ||
                    got.column !== want.column || got.frame_end !== want.frame_end) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: want value=%0d row=%0d col=%0d end=%0b",
                                 want.line_value, want.row, want.column, want.frame_end,
                                 ", got value=%0d row=%0d col=%0d end=%0b",
                                 got.line_value, got.row, got.column, got.frame_end);
                end
            end
        end
    end

    initial begin
        t_stim_row s;
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= pdle_pkg::CFG_FRAME_WIDTH;
        cfg_data       <= '0;
        pix_ch.valid   <= 1'b0;
        pix_ch.payload <= '0;
        fail_count    = 0;
        src_idle_pct  = 34;
        sink_idle_pct = 62;
        prev_pix   = '0;
        row_at     = '0;
        col_at     = '0;
        width_reg  = pdle_pkg::RST_FRAME_WIDTH;
        height_reg = pdle_pkg::RST_FRAME_HEIGHT;
        foreach (line_mem[i]) line_mem[i] = '0;

        // Reset values: a 640-wide first row gives nothing; then cut the row short.
        add_pix(0, 0, NO_RES, NO_RES, NO_RES);
        add_pix(255, 0, NO_RES, NO_RES, NO_RES);
        add_pix(7, 0, NO_RES, NO_RES, NO_RES);
        add_reg(pdle_pkg::CFG_FRAME_WIDTH, 2);        // column 3 now past the last column
        add_pix(9, 0, NO_RES, NO_RES, NO_RES);
        add_reg(pdle_pkg::CFG_FRAME_HEIGHT, 2);       // row 1 becomes the last row
        add_pix(255, 1, mk_res(0, 0, 0, 0), NO_RES, NO_RES);
        add_pix(0, 3, mk_res(0, 0, 1, 0), mk_res(0, 1, 0, 0), mk_res(0, 1, 1, 1));
        // Flat frame: every difference is zero.
        add_pix(128, 0, NO_RES, NO_RES, NO_RES);
        add_pix(128, 0, NO_RES, NO_RES, NO_RES);
        add_pix(128, 1, mk_res(255, 0, 0, 0), NO_RES, NO_RES);
        add_pix(128, 3, mk_res(0, 0, 1, 0), mk_res(255, 1, 0, 0), mk_res(0, 1, 1, 1));
        // Sizes below the range act as two.
        add_reg(pdle_pkg::CFG_FRAME_WIDTH, 1);
        add_reg(pdle_pkg::CFG_FRAME_HEIGHT, 0);
        add_pix(17, -1, NO_RES, NO_RES, NO_RES);
        add_pix(200, -1, NO_RES, NO_RES, NO_RES);
        add_pix(90, -1, NO_RES, NO_RES, NO_RES);
        add_pix(91, -1, NO_RES, NO_RES, NO_RES);
        // 3x3 with a middle row and alternating extremes.
        add_reg(pdle_pkg::CFG_FRAME_WIDTH, 3);
        add_reg(pdle_pkg::CFG_FRAME_HEIGHT, 3);
        add_pix(0, -1, NO_RES, NO_RES, NO_RES);
        add_pix(255, -1, NO_RES, NO_RES, NO_RES);
        add_pix(0, -1, NO_RES, NO_RES, NO_RES);
        add_pix(255, -1, NO_RES, NO_RES, NO_RES);
        add_pix(0, -1, NO_RES, NO_RES, NO_RES);
        add_pix(255, -1, NO_RES, NO_RES, NO_RES);
        add_pix(1, -1, NO_RES, NO_RES, NO_RES);
        add_pix(254, -1, NO_RES, NO_RES, NO_RES);
        add_pix(128, -1, NO_RES, NO_RES, NO_RES);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; rows with known results queue them directly instead of the predictor.
        foreach (stim_rows[i]) begin
            s = stim_rows[i];
            if (s.is_reg) begin
                write_reg(s.reg_idx, s.value);
            end else begin
                push_pixel(s.value[pdle_pkg::PIX_W-1:0], s.n_known < 0);
                if (s.n_known > 0) due_results.push_back(s.k0);
                if (s.n_known > 1) due_results.push_back(s.k1);
                if (s.n_known > 2) due_results.push_back(s.k2);
            end
        end

        // Slow sink.
        run_small_frames(SMALL_ITEMS);

        // Slow source; widest and tallest settings, then shrink both mid-frame.
        src_idle_pct  = 62;
        sink_idle_pct = 34;
        write_reg(pdle_pkg::CFG_FRAME_WIDTH, MAX_W);
        write_reg(pdle_pkg::CFG_FRAME_HEIGHT, 4095);
        repeat (40) push_pixel(pick_pixel(), 1'b1);
        write_reg(pdle_pkg::CFG_FRAME_WIDTH, 3);      // column 40 acts as the last column
        repeat (19) push_pixel(pick_pixel(), 1'b1);
        write_reg(pdle_pkg::CFG_FRAME_HEIGHT, 3);     // row 7 acts as the last row
        finish_frame();
        run_small_frames(SMALL_ITEMS);

        // No idling; width register all ones acts as the maximum width, then shrink mid-row.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(pdle_pkg::CFG_FRAME_WIDTH, 12'hFFF);
        write_reg(pdle_pkg::CFG_FRAME_HEIGHT, 2);
        repeat (24) push_pixel(pick_pixel(), 1'b1);
        write_reg(pdle_pkg::CFG_FRAME_WIDTH, 4);      // column 24 acts as the last column
        finish_frame();
        run_small_frames(SMALL_ITEMS);

        settle();
        if (fail_count == 0 && due_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
